// ===== src/modular_exponentiation_core_macros.svh =====
// Assertion macros shared by the modular exponentiation RTL.
`ifndef MODULAR_EXPONENTIATION_CORE_MACROS_SVH
`define MODULAR_EXPONENTIATION_CORE_MACROS_SVH

// The property is checked on every rising clock edge while reset is released.
`define MODEXP_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// The consequent must hold in the same cycle as the antecedent.
`define MODEXP_ASSERT_IMPL(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) else $error(msg);

`endif

// ===== src/modexp_pkg.sv =====
// Shared constants, command and status types for the modular exponentiation core.
package modexp_pkg;

  localparam int unsigned ValWidth = 30;
  localparam int unsigned InWidth  = 63;

  localparam logic [ValWidth-1:0] Prime = 30'd1000000007;

  // 2^33 mod Prime, used to fold the top bits of a raw 63-bit base.
  localparam logic [63:0] FoldConstWide = (64'd1 << 33) % {34'd0, Prime};
  localparam logic [ValWidth-1:0] FoldConst = FoldConstWide[ValWidth-1:0];

  // Barrett factor floor(2^60 / Prime); it fits in 31 bits.
  localparam logic [63:0] BarrettMuWide = (64'd1 << 60) / {34'd0, Prime};
  localparam logic [30:0] BarrettMu = BarrettMuWide[30:0];

  localparam logic [31:0] PrimeExt   = {2'b00, Prime};
  localparam logic [31:0] TwoPrime   = {1'b0, Prime, 1'b0};
  localparam logic [31:0] ThreePrime = TwoPrime + PrimeExt;

  typedef enum logic [1:0] {
    OP_NONE   = 2'd0,
    OP_REDUCE = 2'd1,
    OP_MUL    = 2'd2,
    OP_SQR    = 2'd3
  } modexp_op_e;

  typedef struct packed {
    modexp_op_e op;
    logic       load;
    logic       shift;
  } modexp_cmd_t;

  typedef struct packed {
    logic busy;
    logic e_zero;
    logic e_lsb;
  } modexp_status_t;

endpackage

// ===== src/modexp_ctrl.sv =====
// Sequencing state machine of the modular exponentiation core.
`include "modular_exponentiation_core_macros.svh"

module modexp_ctrl
  import modexp_pkg::*;
(
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_stall_o,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  output modexp_cmd_t    cmd_o,
  input  modexp_status_t status_i
);

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_RED  = 6'b000010,
    S_BIT  = 6'b000100,
    S_SQR  = 6'b001000,
    S_WAIT = 6'b010000,
    S_DONE = 6'b100000
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d     = state_q;
    cmd_o.op    = OP_NONE;
    cmd_o.load  = 1'b0;
    cmd_o.shift = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_RED;
        end
      end
      S_RED: begin
        cmd_o.op = OP_REDUCE;
        state_d  = S_WAIT;
      end
      S_BIT: begin
        if (status_i.e_zero) begin
          state_d = S_DONE;
        end else if (status_i.e_lsb) begin
          cmd_o.op = OP_MUL;
          state_d  = S_SQR;
        end else begin
          cmd_o.op    = OP_SQR;
          cmd_o.shift = 1'b1;
          state_d     = S_WAIT;
        end
      end
      S_SQR: begin
        cmd_o.op    = OP_SQR;
        cmd_o.shift = 1'b1;
        state_d     = S_WAIT;
      end
      S_WAIT: begin
        if (!status_i.busy) begin
          state_d = S_BIT;
        end
      end
      S_DONE: begin
        if (!out_stall_i) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = (state_q == S_DONE);

  `MODEXP_ASSERT_IMPL(a_done_pipe_idle, state_q == S_DONE, !status_i.busy, "result shown while a product is in flight")
  `MODEXP_ASSERT(a_done_after_scan, $rose(out_valid_o) |-> $past(status_i.e_zero), "result shown before the exponent was used up")

endmodule

// ===== src/modexp_dp.sv =====
// Datapath: operand registers and the shared multiply and Barrett reduction pipeline.
`include "modular_exponentiation_core_macros.svh"

module modexp_dp
  import modexp_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  modexp_cmd_t         cmd_i,
  input  logic [InWidth-1:0]  base_i,
  input  logic [InWidth-1:0]  exponent_i,
  output modexp_status_t      status_o,
  output logic [ValWidth-1:0] power_mod_o
);

  logic [InWidth-1:0]  base_q;
  logic [InWidth-1:0]  e_q;
  logic [ValWidth-1:0] acc_q;
  logic [ValWidth-1:0] b_q;

  logic [ValWidth-1:0] opa, opb;
  logic [32:0]         addend;
  logic                dst_acc;

  // Stage 1: product (plus fold addend), stage 2: Barrett quotient,
  // stage 3: quotient times prime; the final correction feeds write-back.
  logic        v1_q, v2_q, v3_q;
  logic        dst1_q, dst2_q, dst3_q;
  logic [59:0] prod1_q;
  logic [30:0] quo2_q;
  logic [31:0] xlo2_q, xlo3_q, qp3_q;

  logic [59:0] prod_d;
  logic [61:0] quo_wide;
  logic [60:0] qp_wide;
  logic [31:0] rem_raw;
  logic [ValWidth-1:0] rem_mod;

  always_comb begin
    unique case (cmd_i.op)
      OP_REDUCE: begin
        opa     = base_q[InWidth-1:33];
        opb     = FoldConst;
        addend  = base_q[32:0];
        dst_acc = 1'b0;
      end
      OP_MUL: begin
        opa     = acc_q;
        opb     = b_q;
        addend  = '0;
        dst_acc = 1'b1;
      end
      OP_SQR: begin
        opa     = b_q;
        opb     = b_q;
        addend  = '0;
        dst_acc = 1'b0;
      end
      OP_NONE: begin
        opa     = b_q;
        opb     = b_q;
        addend  = '0;
        dst_acc = 1'b0;
      end
      default: begin
        opa     = b_q;
        opb     = b_q;
        addend  = '0;
        dst_acc = 1'b0;
      end
    endcase
  end

  assign prod_d   = ({30'd0, opa} * {30'd0, opb}) + {27'd0, addend};
  assign quo_wide = {31'd0, prod1_q[59:29]} * {31'd0, BarrettMu};
  assign qp_wide  = {30'd0, quo2_q} * {31'd0, Prime};

  // The Barrett quotient is short by at most two, so the remainder is below 3P.
  assign rem_raw = xlo3_q - qp3_q;

  always_comb begin
    if (rem_raw >= TwoPrime) begin
      rem_mod = ValWidth'(rem_raw - TwoPrime);
    end else if (rem_raw >= PrimeExt) begin
      rem_mod = ValWidth'(rem_raw - PrimeExt);
    end else begin
      rem_mod = rem_raw[ValWidth-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      v1_q <= (cmd_i.op != OP_NONE);
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    dst1_q  <= dst_acc;
    prod1_q <= prod_d;
    dst2_q  <= dst1_q;
    quo2_q  <= quo_wide[61:31];
    xlo2_q  <= prod1_q[31:0];
    dst3_q  <= dst2_q;
    qp3_q   <= qp_wide[31:0];
    xlo3_q  <= xlo2_q;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      base_q <= base_i;
      e_q    <= exponent_i;
      acc_q  <= ValWidth'(1);
    end else begin
      if (cmd_i.shift) begin
        e_q <= e_q >> 1;
      end
      if (v3_q) begin
        if (dst3_q) begin
          acc_q <= rem_mod;
        end else begin
          b_q <= rem_mod;
        end
      end
    end
  end

  assign status_o.busy   = v1_q | v2_q | v3_q;
  assign status_o.e_zero = (e_q == '0);
  assign status_o.e_lsb  = e_q[0];
  assign power_mod_o     = acc_q;

  `MODEXP_ASSERT_IMPL(a_barrett_bound, v3_q, rem_raw < ThreePrime, "Barrett remainder out of range")
  `MODEXP_ASSERT_IMPL(a_no_overlap, cmd_i.op != OP_NONE, !v2_q && !v3_q, "new product issued over an older one")

endmodule

// ===== src/modular_exponentiation_core.sv =====
// Top level of the modular exponentiation core (base^exponent mod 1000000007).
//
//   channel | direction | handshake                  | payload
//   --------+-----------+----------------------------+--------------------------
//   in      | to core   | in_valid_i / in_stall_o    | base_i[62:0], exponent_i[62:0]
//   out     | from core | out_valid_o / out_stall_i  | power_mod_o[29:0]
//
// One beat is worked on at a time. The base is first folded and reduced;
// then each exponent bit, up to the highest set bit, costs a squaring, with
// a multiply into the result before it when the bit is set. Once the exponent
// is seen to be used up, the result is shown. The worst case is 63 set
// exponent bits; the run time is set by the single shared multiply and
// Barrett reduction pipeline on the chain of squarings. Reset clears the
// state machine and the pipeline valid flags. While the result waits under
// out_stall_i the input stays stalled.

module modular_exponentiation_core
  import modexp_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic [InWidth-1:0]  base_i,
  input  logic [InWidth-1:0]  exponent_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic [ValWidth-1:0] power_mod_o
);

  // The controller only sees whether the pipeline is busy, whether the exponent
  // is zero and its low bit; the datapath holds every operand and the running result.
  modexp_cmd_t    cmd;
  modexp_status_t status;

  modexp_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .cmd_o       (cmd),
    .status_i    (status)
  );

  modexp_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .base_i      (base_i),
    .exponent_i  (exponent_i),
    .status_o    (status),
    .power_mod_o (power_mod_o)
  );

endmodule
